[sv/imu_temperature_bias_matrix_correct_unit_assert.svh]
// Assertion macros shared by the temperature bias correction block.
// Included by the modules that check their own control logic.
`ifndef IMU_TEMPERATURE_BIAS_MATRIX_CORRECT_UNIT_ASSERT_SVH
`define IMU_TEMPERATURE_BIAS_MATRIX_CORRECT_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define IMU_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define IMU_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

[sv/imutbc_pkg.sv]
// Package for the temperature bias correction block: types and constants.
// No dependencies.
package imutbc_pkg;

    localparam int SetWords = 21;
    localparam int BiasBase = 9;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_REF = 2'd0;
    localparam logic [1:0] REG_MIN = 2'd1;
    localparam logic [1:0] REG_MAX = 2'd2;

    localparam logic signed [15:0] RefReset = 16'sd6400;
    localparam logic signed [15:0] MinReset = -16'sd10240;
    localparam logic signed [15:0] MaxReset = 16'sd25600;
    localparam logic signed [31:0] One = 32'sd65536;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_CORRECT = 1'b1;

    // Reset value of a coefficient slot: identity matrix, zero bias.
    function automatic logic signed [31:0] reset_coef(input logic [4:0] slot);
        logic signed [31:0] v;
        v = '0;
        if (slot == 5'd0 || slot == 5'd4 || slot == 5'd8)
        begin
            v = One;
        end
        return v;
    endfunction

    // Round half up of x/256 then add c; 64-bit wide enough for all ranges.
    function automatic logic signed [63:0] horner_step(
        input logic signed [16:0] dt,
        input logic signed [63:0] acc,
        input logic signed [31:0] c);
        logic signed [63:0] p;
        p = 64'(dt) * acc + 64'sd128;
        return 64'(c) + (p >>> 8);
    endfunction

    function automatic logic fits32(input logic signed [63:0] v);
        return (v >= -64'sd2147483648) && (v <= 64'sd2147483647);
    endfunction

endpackage

[sv/imu_temperature_bias_matrix_correct_unit.sv]
// Top level of the temperature bias and misalignment correction block.
// Depends on imutbc_pkg and the assertion macro header.
//
// One transaction enters per cycle unless the output stalls; a correct
// transaction gives a result, a load gives none. The item kind travels in
// s_tuser and the ok flag of a result in m_tuser. Coefficients live in
// 21 banked synchronous memories (one per slot, SOURCES*2 rows each)
// that are read once in the first stage and written directly by loads.
// A row whose slot was never loaded reads as its reset value through a
// valid bit per entry. Each of the nine Horner multiplies and nine
// matrix products sits in its own stage behind a register, so throughput
// is one item per cycle; a full output stage stalls the whole pipeline.
`include "imu_temperature_bias_matrix_correct_unit_assert.svh"
module imu_temperature_bias_matrix_correct_unit
    import imutbc_pkg::*;
#(
    parameter int SOURCES = 2
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // coefficient_slot, coefficient_value, temperature, sample_x, sample_y,
    // sample_z (149 bits in 152)
    input  logic [151:0] s_tdata,
    // mode, sensor_kind, source
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // corrected_x, corrected_y, corrected_z (96 bits)
    output logic [95:0]  m_tdata,
    // ok
    output logic         m_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    localparam int SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int Rows = SOURCES * 2;
    localparam int RW = $clog2(Rows);
    localparam int Depth = 23;

    typedef struct {
        logic               valid;
        logic               ok;
        logic signed [16:0] dt;
        logic signed [31:0] s [3];
        logic signed [31:0] c [SetWords];
        logic signed [63:0] acc [3];
        logic signed [63:0] r [3];
    } stage_t;

    // Field extraction.
    logic               in_mode, in_kind;
    logic [SW-1:0]      in_src;
    logic               in_src_bad;
    logic [4:0]         in_slot;
    logic signed [31:0] in_val;
    logic signed [15:0] in_temp;
    assign in_mode = s_tuser[0];
    assign in_kind = s_tuser[1];
    assign in_src = SW'(s_tuser[2]);
    assign in_src_bad = (32'(s_tuser[2]) >= SOURCES);
    assign in_slot = s_tdata[4:0];
    assign in_val = s_tdata[36:5];
    assign in_temp = s_tdata[52:37];

    logic [RW-1:0] in_row;
    assign in_row = RW'({in_src, in_kind});

    // Configuration registers.
    logic signed [15:0] ref_reg, min_reg, max_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= RefReset;
            min_reg <= MinReset;
            max_reg <= MaxReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REF: ref_reg <= cfg_data;
                REG_MIN: min_reg <= cfg_data;
                REG_MAX: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    logic accept;
    logic out_valid_reg;
    assign adv = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign accept = s_tvalid && s_tready;

    // Coefficient memories, one per slot, with valid bits per entry.
    logic signed [31:0] mem [SetWords][Rows];
    logic [Rows-1:0]    vld_reg [SetWords];
    logic signed [31:0] rd_reg [SetWords];
    logic               rd_vld_reg [SetWords];
    logic               ld;
    assign ld = accept && in_mode == MODE_LOAD && !in_src_bad;

    genvar g;
    generate
        for (g = 0; g < SetWords; g++)
        begin : g_bank
            always_ff @(posedge clk)
            begin
                if (ld && in_slot == 5'(g))
                begin
                    mem[g][in_row] <= in_val;
                end
                if (adv)
                begin
                    rd_reg[g] <= mem[g][in_row];
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g] <= '0;
                    rd_vld_reg[g] <= 1'b0;
                end
                else
                begin
                    if (adv)
                    begin
                        rd_vld_reg[g] <= vld_reg[g][in_row];
                    end
                    if (ld && in_slot == 5'(g))
                    begin
                        vld_reg[g][in_row] <= 1'b1;
                    end
                end
            end
        end
    endgenerate

    // Stage 0 registers: item fields alongside the memory read.
    logic               v0_reg, ok0_reg;
    logic signed [16:0] dt0_reg;
    logic signed [31:0] s0_reg [3];
    logic signed [15:0] t_clamp;
    always_comb
    begin
        t_clamp = in_temp;
        if (in_temp < min_reg)
        begin
            t_clamp = min_reg;
        end
        else if (in_temp > max_reg)
        begin
            t_clamp = max_reg;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= accept && in_mode == MODE_CORRECT;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok0_reg <= !in_src_bad;
            dt0_reg <= 17'(t_clamp) - 17'(ref_reg);
            s0_reg[0] <= s_tdata[84:53];
            s0_reg[1] <= s_tdata[116:85];
            s0_reg[2] <= s_tdata[148:117];
        end
    end

    // Pipeline: stage 1 loads; 2..10 Horner (axis, power); 11..13 subtract
    // and check; 14..22 matrix products, one per stage; 23 rounding.
    stage_t p_reg [Depth];
    stage_t p_next [Depth];

    always_comb
    begin
        stage_t st;
        int a, k, rr, cc;
        st = p_reg[0];
        st.valid = v0_reg;
        st.ok = ok0_reg;
        st.dt = dt0_reg;
        st.s = s0_reg;
        for (int i = 0; i < SetWords; i++)
        begin
            st.c[i] = rd_vld_reg[i] ? rd_reg[i] : reset_coef(5'(i));
        end
        for (int i = 0; i < 3; i++)
        begin
            st.acc[i] = 64'(st.c[BiasBase + i * 4 + 3]);
            st.r[i] = '0;
        end
        p_next[0] = st;
        for (int n = 1; n < Depth; n++)
        begin
            st = p_reg[n - 1];
            if (n <= 9)
            begin
                a = (n - 1) / 3;
                k = 2 - ((n - 1) % 3);
                st.acc[a] = horner_step(st.dt, st.acc[a], st.c[BiasBase + a * 4 + k]);
                if (!fits32(st.acc[a]))
                begin
                    st.ok = 1'b0;
                    st.acc[a] = '0;
                end
            end
            else if (n <= 12)
            begin
                a = n - 10;
                st.acc[a] = 64'(st.s[a]) - st.acc[a];
                if (!fits32(st.acc[a]))
                begin
                    st.ok = 1'b0;
                    st.acc[a] = '0;
                end
            end
            else if (n <= 21)
            begin
                rr = (n - 13) / 3;
                cc = (n - 13) % 3;
                st.r[rr] = st.r[rr]
                    + 64'(st.c[rr * 3 + cc]) * 64'($signed(st.acc[cc][31:0]));
            end
            else if (n == 22)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    st.r[i] = (st.r[i] + 64'sd32768) >>> 16;
                    if (!fits32(st.r[i]))
                    begin
                        st.ok = 1'b0;
                    end
                end
            end
            p_next[n] = st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < Depth; n++)
            begin
                p_reg[n].valid <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int n = 0; n < Depth; n++)
            begin
                p_reg[n] <= p_next[n];
            end
        end
    end

    // Output register.
    logic [95:0] out_data_reg;
    logic [95:0] out_data_next;
    logic        out_ok_reg;
    logic        out_ok_next;
    stage_t fin;
    always_comb
    begin
        fin = p_reg[Depth - 1];
        out_data_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            out_data_next[i * 32 +: 32] = fin.ok ? fin.r[i][31:0] : fin.s[i];
        end
        out_ok_next = fin.ok;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= fin.valid;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_ok_reg <= out_ok_next;
        end
    end
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_ok_reg;

    `IMU_ASSERT_IMPL(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, !s_tready)
    `IMU_ASSERT_NEXT(a_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `IMU_ASSERT_NEXT(a_hold_user, clk, rst_n, m_tvalid && !m_tready, $stable(m_tuser))
    `IMU_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

endmodule
